### hw/rtl/tfn_pkg.sv
// Shared types and constants for the triangle flat normal pipeline.
package tfn_pkg;

  localparam int INDEX_BITS  = 16;
  localparam int POS_BITS    = 32;
  localparam int EDGE_BITS   = 33;
  localparam int PROD_BITS   = 66;
  localparam int MAG_BITS    = 65;
  localparam int LEN_BITS    = 7;
  localparam int TARGET_BITS = 30;
  localparam int SUM_BITS    = 64;
  localparam int ROOT_BITS   = 31;
  localparam int QUOT_BITS   = 15;
  localparam int DIV_BITS    = 47;
  localparam int NORM_BITS   = 16;

  typedef struct packed {
    logic [INDEX_BITS-1:0]      index_a;
    logic [INDEX_BITS-1:0]      index_b;
    logic [INDEX_BITS-1:0]      index_c;
    logic signed [POS_BITS-1:0] pos_a_x;
    logic signed [POS_BITS-1:0] pos_a_y;
    logic signed [POS_BITS-1:0] pos_a_z;
    logic signed [POS_BITS-1:0] pos_b_x;
    logic signed [POS_BITS-1:0] pos_b_y;
    logic signed [POS_BITS-1:0] pos_b_z;
    logic signed [POS_BITS-1:0] pos_c_x;
    logic signed [POS_BITS-1:0] pos_c_y;
    logic signed [POS_BITS-1:0] pos_c_z;
  } item_t;

  typedef struct packed {
    logic signed [NORM_BITS-1:0] normal_x;
    logic signed [NORM_BITS-1:0] normal_y;
    logic signed [NORM_BITS-1:0] normal_z;
    logic [INDEX_BITS-1:0]       out_index_a;
    logic [INDEX_BITS-1:0]       out_index_b;
    logic [INDEX_BITS-1:0]       out_index_c;
    logic                        index_error;
  } result_t;

  // Side data that rides along with every triangle.
  typedef struct packed {
    logic [INDEX_BITS-1:0] index_a;
    logic [INDEX_BITS-1:0] index_b;
    logic [INDEX_BITS-1:0] index_c;
    logic                  err;
  } meta_t;

endpackage

### hw/rtl/triangle_flat_normal.sv
// Top level of the triangle flat normal pipeline.
//
// One triangle enters as a transaction on item when start is high and busy
// is low. The block forms the edges b - a and c - a, their exact cross
// product, scales the vector so its largest component has 30 significant
// bits, takes the integer square root of the sum of squares and divides each
// component by it, giving a unit normal in signed Q1.14 rounded half up.
// A degenerate triangle gives a zero normal. The three indices pass through,
// and index_error is set when any index is at or above vertex_count.
// The pipeline never stalls, so busy stays low and one triangle can enter
// on every clock. Each result appears on result with done high for exactly
// one cycle; the receiver has no way to hold it off and must take it then.
// The depth is set by the square root, which retires one root bit per stage
// (31 stages), and the divider, which retires one quotient bit per stage
// (15 stages).
// vertex_count is written over the cfg channel, which is always ready; it
// is meant to change only while no triangle is in flight.
// Synchronous reset clears vertex_count and every valid bit; data in
// flight is dropped.
module triangle_flat_normal (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  tfn_pkg::item_t                      item,
  output logic                                done,
  output tfn_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tfn_pkg::INDEX_BITS-1:0]      cfg_data
);

  localparam int EB = tfn_pkg::EDGE_BITS;
  localparam int PB = tfn_pkg::PROD_BITS;
  localparam int MB = tfn_pkg::MAG_BITS;
  localparam int LB = tfn_pkg::LEN_BITS;
  localparam int TB = tfn_pkg::TARGET_BITS;
  localparam int SB = tfn_pkg::SUM_BITS;
  localparam int RB = tfn_pkg::ROOT_BITS;
  localparam int QB = tfn_pkg::QUOT_BITS;
  localparam int DB = tfn_pkg::DIV_BITS;
  localparam int NB = tfn_pkg::NORM_BITS;

  logic [tfn_pkg::INDEX_BITS-1:0] vertex_count;
  logic                           accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  // Stage 1: edges and index check.
  logic                 s1_v;
  tfn_pkg::meta_t       s1_meta;
  logic signed [EB-1:0] e1x, e1y, e1z, e2x, e2y, e2z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= accept;
    end
    s1_meta.index_a <= item.index_a;
    s1_meta.index_b <= item.index_b;
    s1_meta.index_c <= item.index_c;
    s1_meta.err     <= (item.index_a >= vertex_count) || (item.index_b >= vertex_count) ||
                       (item.index_c >= vertex_count);
    e1x <= EB'(item.pos_b_x) - EB'(item.pos_a_x);
    e1y <= EB'(item.pos_b_y) - EB'(item.pos_a_y);
    e1z <= EB'(item.pos_b_z) - EB'(item.pos_a_z);
    e2x <= EB'(item.pos_c_x) - EB'(item.pos_a_x);
    e2y <= EB'(item.pos_c_y) - EB'(item.pos_a_y);
    e2z <= EB'(item.pos_c_z) - EB'(item.pos_a_z);
  end

  // Stage 2: the six partial products of the cross product.
  logic                 s2_v;
  tfn_pkg::meta_t       s2_meta;
  logic signed [PB-1:0] pr [0:5];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_meta <= s1_meta;
    pr[0]   <= e1y * e2z;
    pr[1]   <= e1z * e2y;
    pr[2]   <= e1z * e2x;
    pr[3]   <= e1x * e2z;
    pr[4]   <= e1x * e2y;
    pr[5]   <= e1y * e2x;
  end

  // Stage 3: cross components as sign and magnitude.
  logic                 s3_v;
  tfn_pkg::meta_t       s3_meta;
  logic [2:0]           s3_neg;
  logic [MB-1:0]        s3_mag [0:2];
  logic signed [PB:0]   diff [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = (PB+1)'(pr[2*i]) - (PB+1)'(pr[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else begin
      s3_v <= s2_v;
    end
    s3_meta <= s2_meta;
    for (int i = 0; i < 3; i++) begin
      s3_neg[i] <= diff[i][PB];
      s3_mag[i] <= diff[i][PB] ? MB'(-diff[i]) : MB'(diff[i]);
    end
  end

  // Stage 4: bit length of the largest component.
  logic                 s4_v;
  tfn_pkg::meta_t       s4_meta;
  logic [2:0]           s4_neg;
  logic [MB-1:0]        s4_mag [0:2];
  logic [LB-1:0]        s4_len;
  logic [MB-1:0]        any_bits;
  logic [LB-1:0]        len_next;

  always_comb begin
    any_bits = s3_mag[0] | s3_mag[1] | s3_mag[2];
    len_next = '0;
    for (int i = 0; i < MB; i++) begin
      if (any_bits[i]) begin
        len_next = LB'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else begin
      s4_v <= s3_v;
    end
    s4_meta <= s3_meta;
    s4_neg  <= s3_neg;
    s4_mag  <= s3_mag;
    s4_len  <= len_next;
  end

  // Stage 5: common block scaling to 30 significant bits.
  logic                 s5_v;
  tfn_pkg::meta_t       s5_meta;
  logic [2:0]           s5_neg;
  logic [2:0][TB-1:0]   s5_r;
  logic [MB-1:0]        shifted [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s4_len > LB'(TB)) begin
        shifted[i] = s4_mag[i] >> (s4_len - LB'(TB));
      end else begin
        shifted[i] = s4_mag[i] << (LB'(TB) - s4_len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else begin
      s5_v <= s4_v;
    end
    s5_meta <= s4_meta;
    s5_neg  <= s4_neg;
    for (int i = 0; i < 3; i++) begin
      s5_r[i] <= shifted[i][TB-1:0];
    end
  end

  // Stage 6: squares.
  logic                 s6_v;
  tfn_pkg::meta_t       s6_meta;
  logic [2:0]           s6_neg;
  logic [2:0][TB-1:0]   s6_r;
  logic [2*TB-1:0]      s6_sq [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else begin
      s6_v <= s5_v;
    end
    s6_meta <= s5_meta;
    s6_neg  <= s5_neg;
    s6_r    <= s5_r;
    for (int i = 0; i < 3; i++) begin
      s6_sq[i] <= s5_r[i] * s5_r[i];
    end
  end

  // Square root: stage 0 holds the sum of squares, each later stage
  // settles one root bit, most significant first.
  logic                 sq_v    [0:RB];
  tfn_pkg::meta_t       sq_meta [0:RB];
  logic [2:0]           sq_neg  [0:RB];
  logic [2:0][TB-1:0]   sq_r    [0:RB];
  logic [SB-1:0]        sq_rem  [0:RB];
  logic [RB-1:0]        sq_root [0:RB];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else begin
      sq_v[0] <= s6_v;
    end
    sq_meta[0] <= s6_meta;
    sq_neg[0]  <= s6_neg;
    sq_r[0]    <= s6_r;
    sq_rem[0]  <= SB'(s6_sq[0]) + SB'(s6_sq[1]) + SB'(s6_sq[2]);
    sq_root[0] <= '0;
  end

  for (genvar j = 1; j <= RB; j++) begin : g_sqrt
    localparam int K = RB - j;
    logic [SB-1:0] trial;
    logic          take;

    assign trial = (SB'(sq_root[j-1]) << (K + 1)) + (SB'(1) << (2 * K));
    assign take  = sq_rem[j-1] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j] <= 1'b0;
      end else begin
        sq_v[j] <= sq_v[j-1];
      end
      sq_meta[j] <= sq_meta[j-1];
      sq_neg[j]  <= sq_neg[j-1];
      sq_r[j]    <= sq_r[j-1];
      sq_rem[j]  <= take ? sq_rem[j-1] - trial : sq_rem[j-1];
      sq_root[j] <= take ? (sq_root[j-1] | (RB'(1) << K)) : sq_root[j-1];
    end
  end

  // Division: stage 0 loads r * 2^15 + L and the divisor 2L, each later
  // stage settles one quotient bit in all three lanes.
  logic                 dv_v    [0:QB];
  tfn_pkg::meta_t       dv_meta [0:QB];
  logic [2:0]           dv_neg  [0:QB];
  logic [RB:0]          dv_d    [0:QB];
  logic [2:0][DB-1:0]   dv_rem  [0:QB];
  logic [2:0][QB-1:0]   dv_q    [0:QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else begin
      dv_v[0] <= sq_v[RB];
    end
    dv_meta[0] <= sq_meta[RB];
    dv_neg[0]  <= sq_neg[RB];
    dv_d[0]    <= {sq_root[RB], 1'b0};
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= (DB'(sq_r[RB][i]) << QB) + DB'(sq_root[RB]);
      dv_q[0][i]   <= '0;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_div
    localparam int K = QB - j;
    logic [DB-1:0] step;

    assign step = DB'(dv_d[j-1]) << K;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j] <= 1'b0;
      end else begin
        dv_v[j] <= dv_v[j-1];
      end
      dv_meta[j] <= dv_meta[j-1];
      dv_neg[j]  <= dv_neg[j-1];
      dv_d[j]    <= dv_d[j-1];
      for (int i = 0; i < 3; i++) begin
        if (dv_rem[j-1][i] >= step) begin
          dv_rem[j][i] <= dv_rem[j-1][i] - step;
          dv_q[j][i]   <= dv_q[j-1][i] | (QB'(1) << K);
        end else begin
          dv_rem[j][i] <= dv_rem[j-1][i];
          dv_q[j][i]   <= dv_q[j-1][i];
        end
      end
    end
  end

  // Output register: a zero length means a degenerate triangle.
  logic [NB-1:0] mag_out [0:2];
  logic [NB-1:0] val_out [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_out[i] = (dv_d[QB] == '0) ? '0 : NB'(dv_q[QB][i]);
      val_out[i] = dv_neg[QB][i] ? NB'(-mag_out[i]) : mag_out[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_v[QB];
    end
    result.normal_x    <= val_out[0];
    result.normal_y    <= val_out[1];
    result.normal_z    <= val_out[2];
    result.out_index_a <= dv_meta[QB].index_a;
    result.out_index_b <= dv_meta[QB].index_b;
    result.out_index_c <= dv_meta[QB].index_c;
    result.index_error <= dv_meta[QB].err;
  end

endmodule

### bench/triangle_flat_normal_tb.sv
// Self-checking testbench for the triangle flat normal pipeline.
module triangle_flat_normal_tb;

  localparam int LATENCY   = 55;
  localparam int WATCHDOG  = 2000;
  localparam int N_RANDOM  = 600;
  localparam int MAX_SHOWN = 10;

  // Directed rows: kind tells how each row is built.
  typedef enum int {
    ROW_ZERO, ROW_UNIT_Z, ROW_NEG_Z, ROW_UNIT_X, ROW_UNIT_Y, ROW_MAX_SPAN, ROW_MIN_SPAN,
    ROW_COLLINEAR, ROW_IDX_MAX, ROW_RANDOM
  } row_kind_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  tfn_pkg::item_t   item = '0;
  logic             done;
  tfn_pkg::result_t result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [tfn_pkg::INDEX_BITS-1:0] cfg_data = '0;

  // Mirror of the vertex count register.
  logic [tfn_pkg::INDEX_BITS-1:0] vcount_model;

  // Normals still in flight, oldest first.
  tfn_pkg::result_t pending_normals[$];

  int mismatches = 0;
  int checked = 0;
  int idle_cycles = 0;
  int errors_seen = 0;
  bit timed_out = 1'b0;

  triangle_flat_normal u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Integer square root of a 64-bit value, bit by bit.
  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Computes the flat normal and the index check for one triangle.
  function automatic tfn_pkg::result_t face_normal(input tfn_pkg::item_t t,
                                                   input logic [tfn_pkg::INDEX_BITS-1:0] vc);
    tfn_pkg::result_t o;
    logic signed [tfn_pkg::EDGE_BITS-1:0] e1 [3];
    logic signed [tfn_pkg::EDGE_BITS-1:0] e2 [3];
    logic signed [tfn_pkg::PROD_BITS+1:0] cr [3];
    logic [tfn_pkg::PROD_BITS+1:0] mag [3];
    logic [63:0] r [3];
    logic [63:0] sum, len, q;
    logic [15:0] n [3];
    int maxlen;
    e1[0] = tfn_pkg::EDGE_BITS'(t.pos_b_x) - tfn_pkg::EDGE_BITS'(t.pos_a_x);
    e1[1] = tfn_pkg::EDGE_BITS'(t.pos_b_y) - tfn_pkg::EDGE_BITS'(t.pos_a_y);
    e1[2] = tfn_pkg::EDGE_BITS'(t.pos_b_z) - tfn_pkg::EDGE_BITS'(t.pos_a_z);
    e2[0] = tfn_pkg::EDGE_BITS'(t.pos_c_x) - tfn_pkg::EDGE_BITS'(t.pos_a_x);
    e2[1] = tfn_pkg::EDGE_BITS'(t.pos_c_y) - tfn_pkg::EDGE_BITS'(t.pos_a_y);
    e2[2] = tfn_pkg::EDGE_BITS'(t.pos_c_z) - tfn_pkg::EDGE_BITS'(t.pos_a_z);
    cr[0] = 68'(e1[1]) * 68'(e2[2]) - 68'(e1[2]) * 68'(e2[1]);
    cr[1] = 68'(e1[2]) * 68'(e2[0]) - 68'(e1[0]) * 68'(e2[2]);
    cr[2] = 68'(e1[0]) * 68'(e2[1]) - 68'(e1[1]) * 68'(e2[0]);
    maxlen = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
      for (int b = 0; b < 68; b++) if (mag[i][b] && b + 1 > maxlen) maxlen = b + 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (maxlen > tfn_pkg::TARGET_BITS)
        r[i] = 64'(mag[i] >> (maxlen - tfn_pkg::TARGET_BITS));
      else r[i] = 64'(mag[i]) << (tfn_pkg::TARGET_BITS - maxlen);
      sum = sum + r[i] * r[i];
    end
    len = root64(sum);
    for (int i = 0; i < 3; i++) begin
      q = (len == 0) ? 64'd0 : (2 * r[i] * 64'd16384 + len) / (2 * len);
      n[i] = cr[i] < 0 ? 16'(-q) : 16'(q);
    end
    o.normal_x = n[0];
    o.normal_y = n[1];
    o.normal_z = n[2];
    o.out_index_a = t.index_a;
    o.out_index_b = t.index_b;
    o.out_index_c = t.index_c;
    o.index_error = (t.index_a >= vc) || (t.index_b >= vc) || (t.index_c >= vc);
    return o;
  endfunction

  // Coordinates with a bias toward edge values so the top bits toggle.
  function automatic logic [31:0] draw_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 8192)) - 4096) << 16;
      3: return 32'($signed($urandom_range(0, 64)) - 32);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [tfn_pkg::INDEX_BITS-1:0] draw_index(
      input logic [tfn_pkg::INDEX_BITS-1:0] vc);
    if (vc != 0 && $urandom_range(0, 9) < 8)
      return tfn_pkg::INDEX_BITS'($urandom_range(0, vc - 1));
    return tfn_pkg::INDEX_BITS'($urandom);
  endfunction

  function automatic tfn_pkg::item_t random_triangle(input logic [tfn_pkg::INDEX_BITS-1:0] vc);
    tfn_pkg::item_t t;
    t.index_a = draw_index(vc);
    t.index_b = draw_index(vc);
    t.index_c = draw_index(vc);
    t.pos_a_x = draw_coord(); t.pos_a_y = draw_coord(); t.pos_a_z = draw_coord();
    t.pos_b_x = draw_coord(); t.pos_b_y = draw_coord(); t.pos_b_z = draw_coord();
    t.pos_c_x = draw_coord(); t.pos_c_y = draw_coord(); t.pos_c_z = draw_coord();
    // Now and then make the triangle flat: c lies on the line through a and b.
    if ($urandom_range(0, 19) == 0) begin
      t.pos_c_x = t.pos_b_x; t.pos_c_y = t.pos_b_y; t.pos_c_z = t.pos_b_z;
    end
    return t;
  endfunction

  // Builds one directed row; the expectation is filled in where obvious.
  function automatic tfn_pkg::item_t directed_triangle(input row_kind_t kind,
                                                       output bit has_exp,
                                                       output tfn_pkg::result_t exp_r);
    tfn_pkg::item_t t;
    t = '0;
    has_exp = 1'b1;
    exp_r = '0;
    case (kind)
      ROW_ZERO: ;
      ROW_UNIT_Z: begin
        t.pos_b_x = 32'h0001_0000; t.pos_c_y = 32'h0001_0000;
        exp_r.normal_z = 16'sd16384;
      end
      ROW_NEG_Z: begin
        t.pos_b_y = 32'h0001_0000; t.pos_c_x = 32'h0001_0000;
        exp_r.normal_z = -16'sd16384;
      end
      ROW_UNIT_X: begin
        t.pos_b_y = 32'h0000_0001; t.pos_c_z = 32'h0000_0001;
        exp_r.normal_x = 16'sd16384;
      end
      ROW_UNIT_Y: begin
        t.pos_b_z = 32'h0100_0000; t.pos_c_x = 32'h0100_0000;
        exp_r.normal_y = 16'sd16384;
      end
      ROW_MAX_SPAN: begin
        t.pos_a_x = 32'h8000_0000; t.pos_a_y = 32'h8000_0000; t.pos_a_z = 32'h8000_0000;
        t.pos_b_x = 32'h7FFF_FFFF; t.pos_b_y = 32'h8000_0000; t.pos_b_z = 32'h8000_0000;
        t.pos_c_x = 32'h8000_0000; t.pos_c_y = 32'h7FFF_FFFF; t.pos_c_z = 32'h8000_0000;
        exp_r.normal_z = 16'sd16384;
      end
      ROW_MIN_SPAN: begin
        t.pos_a_x = 32'h7FFF_FFFF; t.pos_a_y = 32'h7FFF_FFFF; t.pos_a_z = 32'h7FFF_FFFF;
        t.pos_b_x = 32'h8000_0000; t.pos_b_y = 32'h8000_0000; t.pos_b_z = 32'h8000_0000;
        t.pos_c_x = 32'h8000_0000; t.pos_c_y = 32'h7FFF_FFFF; t.pos_c_z = 32'h8000_0000;
        has_exp = 1'b0;
      end
      ROW_COLLINEAR: begin
        t.pos_b_x = 32'h0002_0000; t.pos_b_y = 32'h0002_0000;
        t.pos_c_x = 32'h0004_0000; t.pos_c_y = 32'h0004_0000;
      end
      ROW_IDX_MAX: begin
        t.index_a = '1; t.index_b = '1; t.index_c = '1;
        exp_r.out_index_a = '1; exp_r.out_index_b = '1; exp_r.out_index_c = '1;
      end
      default: has_exp = 1'b0;
    endcase
    if (kind != ROW_IDX_MAX && kind != ROW_RANDOM) begin
      t.index_a = 16'd0; t.index_b = 16'd1; t.index_c = 16'd2;
      exp_r.out_index_a = 16'd0; exp_r.out_index_b = 16'd1; exp_r.out_index_c = 16'd2;
    end
    return t;
  endfunction

  // Result checker: every done pulse is one transaction that must match the oldest entry.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected result %h", result);
      end else begin
        tfn_pkg::result_t want;
        want = pending_normals.pop_front();
        checked++;
        if (want.index_error) errors_seen++;
        if (result !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("mismatch: expected n=(%0d,%0d,%0d) idx=(%0d,%0d,%0d) err=%0b",
                     want.normal_x, want.normal_y, want.normal_z, want.out_index_a,
                     want.out_index_b, want.out_index_c, want.index_error);
            $display("          got      n=(%0d,%0d,%0d) idx=(%0d,%0d,%0d) err=%0b",
                     result.normal_x, result.normal_y, result.normal_z, result.out_index_a,
                     result.out_index_b, result.out_index_c, result.index_error);
          end
        end
      end
    end
  end

  // Watchdog: counts cycles in which no triangle or cfg write is accepted and no result arrives.
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired with %0d results outstanding", pending_normals.size());
      $display("[triangle_flat_normal] ERROR");
      $finish;
    end
  end

  // Sends one triangle transaction after a gap of idle cycles; the prediction is queued
  // at acceptance. Start is left high so that the next call can follow with no gap;
  // whoever stops sending lowers it.
  task automatic send_triangle(input tfn_pkg::item_t t, input bit has_exp,
                               input tfn_pkg::result_t exp_r, input int gap);
    tfn_pkg::result_t pred;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    item <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = face_normal(t, vcount_model);
    if (has_exp) begin
      // The typed-in value is checked against the predictor as well as the block.
      exp_r.index_error = pred.index_error;
      if (exp_r !== pred) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("directed row disagrees with predictor: %h vs %h",
                                              exp_r, pred);
      end
      pending_normals = {pending_normals, exp_r};
    end else begin
      pending_normals = {pending_normals, pred};
    end
    @(negedge clk);
  endtask

  // Waits for all results, then lets the pipeline drain before a register write.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_normals.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_vertex_count(input logic [tfn_pkg::INDEX_BITS-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    vcount_model = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [tfn_pkg::INDEX_BITS-1:0] counts [5];
    bit has_exp;
    tfn_pkg::result_t exp_r;
    tfn_pkg::item_t t;
    int per_phase;
    vcount_model = '0;
    counts[0] = 16'd3;
    counts[1] = 16'hFFFF;
    counts[2] = 16'd1;
    counts[3] = 16'd0;
    counts[4] = 16'd1000;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table, first with the reset count of zero, then after a write of three.
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        drain_pipeline();
        write_vertex_count(counts[0]);
      end
      for (int k = ROW_ZERO; k <= ROW_RANDOM; k++) begin
        t = directed_triangle(row_kind_t'(k), has_exp, exp_r);
        if (k == ROW_RANDOM) t = random_triangle(vcount_model);
        send_triangle(t, has_exp, exp_r, $urandom_range(0, 4));
      end
    end

    // Random phases, each under its own vertex count.
    per_phase = N_RANDOM / 5;
    for (int ph = 0; ph < 5; ph++) begin
      drain_pipeline();
      write_vertex_count(ph == 4 ? tfn_pkg::INDEX_BITS'($urandom) : counts[(ph + 1) % 5]);
      for (int n = 0; n < per_phase; n++) begin
        // Back-to-back bursts in places so gaps do not fall on every item.
        send_triangle(random_triangle(vcount_model), 1'b0, exp_r,
                      (n % 40 < 10) ? 0 : int'($urandom_range(0, 4)));
        // Hold off once mid-phase until every result has come back.
        if (n == per_phase / 2) begin
          start <= 1'b0;
          while (pending_normals.size() != 0) @(negedge clk);
        end
      end
    end

    drain_pipeline();
    $display("checked %0d triangle results over several vertex counts, %0d with index errors",
             checked, errors_seen);
    if (mismatches == 0) begin
      $display("[triangle_flat_normal] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[triangle_flat_normal] ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/tfn_pkg.sv
hw/rtl/triangle_flat_normal.sv
bench/triangle_flat_normal_tb.sv
